@@ rtl/msp_pkg.sv @@
package msp_pkg;

   // Sizes of the stack set and of the shared node pool.
   localparam int MAX_STACKS = 8;
   localparam int POOL_DEPTH = 256;
   localparam int DATA_WIDTH = 32;

   // Node pointers carry one extra bit so that POOL_DEPTH itself marks null.
   localparam int ADDR_W = $clog2(POOL_DEPTH);
   localparam int NODE_W = ADDR_W + 1;
   localparam logic [NODE_W-1:0] NODE_NULL = NODE_W'(POOL_DEPTH);

   // Fixed field widths.
   localparam int IDX_W    = 3;
   localparam int ACTIVE_W = 4;
   localparam int STAT_W   = 2;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);

   // Operation codes.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // latch the request beat and launch the node reads
      logic commit;   // update the stacks and load the result register
   } dp_cmd_type;

endpackage

@@ rtl/msp_ram.sv @@
module msp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/msp_dp.sv @@
module msp_dp
   import msp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [DATA_WIDTH-1:0] req_tdata,
   input  logic [IDX_W:0]        req_tuser,
   input  logic                  csr_we,
   input  logic [ACTIVE_W-1:0]   csr_data,
   output logic [DATA_WIDTH-1:0] rsp_tdata,
   output logic [STAT_W-1:0]     rsp_tuser
);

   // Latched request and architectural state.
   logic                  op_cmd_ff;
   logic [IDX_W-1:0]      op_idx_ff;
   logic [DATA_WIDTH-1:0] op_val_ff;
   logic [ACTIVE_W-1:0]   active_ff;
   logic [NODE_W-1:0]     top_ff [MAX_STACKS];
   logic [NODE_W-1:0]     free_head_ff;
   logic [NODE_W-1:0]     fresh_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic [STAT_W-1:0]     rsp_status_ff;

   // Next values.
   logic [NODE_W-1:0]     top_in;
   logic                  top_we;
   logic [NODE_W-1:0]     free_head_in;
   logic [NODE_W-1:0]     fresh_in;
   logic [DATA_WIDTH-1:0] rsp_data_in;
   logic [STAT_W-1:0]     rsp_status_in;

   // Memory ports.
   logic                  in_cmd;
   logic [IDX_W-1:0]      in_idx;
   logic [NODE_W-1:0]     in_top;
   logic [ADDR_W-1:0]     link_rd_addr;
   logic [NODE_W-1:0]     link_rd_data;
   logic [DATA_WIDTH-1:0] val_rd_data;
   logic                  val_we;
   logic                  link_we;
   logic [ADDR_W-1:0]     val_wr_addr;
   logic [ADDR_W-1:0]     link_wr_addr;
   logic [NODE_W-1:0]     link_wr_data;

   // Execution terms.
   logic                  idx_ok;
   logic [NODE_W-1:0]     cur_top;
   logic                  top_ok;
   logic                  free_ok;
   logic                  fresh_ok;
   logic [NODE_W-1:0]     new_node;
   logic                  push_got;
   logic                  pop_ok;

   // Read launch: a pop reads the node at the stack top, a push reads the free-list link.
   assign in_cmd       = req_tuser[0];
   assign in_idx       = req_tuser[IDX_W:1];
   assign in_top       = top_ff[in_idx];
   assign link_rd_addr = (in_cmd == CMD_POP) ? in_top[ADDR_W-1:0]
                                             : free_head_ff[ADDR_W-1:0];

   msp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wr_addr),
      .wr_data (op_val_ff),
      .rd_en   (cmd.accept),
      .rd_addr (in_top[ADDR_W-1:0]),
      .rd_data (val_rd_data)
   );

   msp_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   // Decode of the latched operation against the current stack state.
   assign idx_ok   = ({1'b0, op_idx_ff} < active_ff)
                  && ({1'b0, op_idx_ff} < (IDX_W+1)'(MAX_STACKS));
   assign cur_top  = top_ff[op_idx_ff];
   assign top_ok   = cur_top < NODE_NULL;
   assign free_ok  = free_head_ff < NODE_NULL;
   assign fresh_ok = fresh_ff < NODE_NULL;
   assign new_node = free_ok ? free_head_ff : fresh_ff;
   assign push_got = (op_cmd_ff == CMD_PUSH) && idx_ok && (free_ok || fresh_ok);
   assign pop_ok   = (op_cmd_ff == CMD_POP) && idx_ok && top_ok;

   // Result and state updates for the operation being committed.
   always_comb begin
      top_in        = cur_top;
      top_we        = 1'b0;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      rsp_data_in   = '0;
      rsp_status_in = ST_OK;
      priority if (!idx_ok) begin
         rsp_status_in = ST_INVALID;
         if (op_cmd_ff == CMD_POP) begin
            rsp_data_in = '1;
         end
      end else if (op_cmd_ff == CMD_PUSH) begin
         if (push_got) begin
            top_in = new_node;
            top_we = 1'b1;
            if (free_ok) begin
               free_head_in = link_rd_data;
            end else begin
               fresh_in = fresh_ff + NODE_W'(1);
            end
         end else begin
            rsp_status_in = ST_EXHAUSTED;
         end
      end else if (top_ok) begin
         rsp_data_in  = val_rd_data;
         top_in       = link_rd_data;
         top_we       = 1'b1;
         free_head_in = cur_top;
      end else begin
         rsp_status_in = ST_UNDERFLOW;
         rsp_data_in   = '1;
      end
   end

   // Node writes: a push fills the new node, a pop links its node onto the free list.
   assign val_we       = cmd.commit && push_got;
   assign val_wr_addr  = new_node[ADDR_W-1:0];
   assign link_we      = cmd.commit && (push_got || pop_ok);
   assign link_wr_addr = pop_ok ? cur_top[ADDR_W-1:0] : new_node[ADDR_W-1:0];
   assign link_wr_data = pop_ok ? free_head_ff : cur_top;

   // Control state of the pool.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         free_head_ff <= NODE_NULL;
         fresh_ff     <= '0;
         for (int i = 0; i < MAX_STACKS; i++) begin
            top_ff[i] <= NODE_NULL;
         end
      end else begin
         if (csr_we) begin
            active_ff <= csr_data;
         end
         if (cmd.commit) begin
            free_head_ff <= free_head_in;
            fresh_ff     <= fresh_in;
            if (top_we) begin
               top_ff[op_idx_ff] <= top_in;
            end
         end
      end
   end

   // Request and result payload.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_cmd_ff <= in_cmd;
         op_idx_ff <= in_idx;
         op_val_ff <= req_tdata;
      end
      if (cmd.commit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;

   // The fresh counter never passes the pool size.
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NODE_NULL)
      else $error("fresh node counter beyond pool size");

   // A node only goes back to the free list from a successful pop.
   a_free_from_pop: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && pop_ok) |=> (free_head_ff == $past(cur_top)))
      else $error("popped node not at free-list head");

   // The fresh counter moves only on a push with an empty free list.
   a_fresh_step: assert property (@(posedge clock) disable iff (reset)
      (fresh_ff != $past(fresh_ff)) |-> $past(cmd.commit && push_got && !free_ok))
      else $error("fresh counter moved without a fresh allocation");

endmodule

@@ rtl/msp_ctrl.sv @@
module msp_ctrl
   import msp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   // The result register is free when empty or being drained this cycle.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign cmd.accept = req_tvalid && req_tready;
   assign cmd.commit = (state_ff == S_EXEC) && slot_free;

   // Next state: a beat is taken in idle, then committed once the result slot is free.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // An accepted beat always moves to execution.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_EXEC))
      else $error("accepted beat not executed");

   // A commit always presents a result in the next cycle.
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit without result");

   // Execution waits, without committing, while the result slot is held.
   a_exec_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EXEC) && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_EXEC))
      else $error("execution left while result slot was full");

endmodule

@@ rtl/multi_stack_shared_pool.sv @@
// An accepted request beat first has its node memory reads registered; it is committed
// once the result register is free, which updates the stacks and loads its result into
// the output register, from which the result beat is offered on the result channel.
// A new request beat is taken only in idle, after the previous beat has been committed,
// as the registered read of the node memories lies between acceptance and the update.
// Reset (synchronous, active high) empties all stacks and the free list, clears the
// fresh-node counter and sets active_stacks to 8; node memories are not cleared.
module multi_stack_shared_pool
   import msp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,   // push_value
   input  logic [IDX_W:0]        req_tuser,   // command, stack_index
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,   // pop_value
   output logic [STAT_W-1:0]     rsp_tuser,   // status
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ACTIVE_W-1:0]   csr_data     // active_stacks
);

   dp_cmd_type cmd;

   // Register writes are taken in any cycle.
   assign csr_ready = 1'b1;

   msp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   msp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ test/multi_stack_shared_pool_checker.sv @@
`timescale 1ns / 100ps

module multi_stack_shared_pool_checker
   import msp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,   // push_value
   input  logic [IDX_W:0]        req_tuser,   // command, stack_index
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DATA_WIDTH-1:0] rsp_tdata,   // pop_value
   input  logic [STAT_W-1:0]     rsp_tuser,   // status
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [ACTIVE_W-1:0]   csr_data,    // active_stacks
   output int                    errors,
   output int                    pending
);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] pop_value;
      logic [STAT_W-1:0]     status;
   } reply_type;

   // Shadow copy of the stacks, the node pool and the free list.
   logic [ACTIVE_W-1:0]   active_count;
   logic [NODE_W-1:0]     top_of [MAX_STACKS];
   logic [DATA_WIDTH-1:0] node_data [POOL_DEPTH];
   logic [NODE_W-1:0]     node_next [POOL_DEPTH];
   logic [NODE_W-1:0]     free_list_head;
   int unsigned           fresh_used;
   reply_type             replies_due [$];

   // Applies one push or pop to the shadow state and returns the reply it earns.
   function automatic reply_type apply_stack_op(input logic cmd,
                                                input logic [IDX_W-1:0] idx,
                                                input logic [DATA_WIDTH-1:0] value);
      reply_type         r;
      logic [NODE_W-1:0] node;
      logic              idx_ok;
      r.pop_value = '0;
      r.status    = ST_OK;
      node        = NODE_NULL;
      idx_ok      = (int'(idx) < int'(active_count)) && (int'(idx) < MAX_STACKS);
      if (!idx_ok) begin
         r.status = ST_INVALID;
         if (cmd == CMD_POP) r.pop_value = '1;
      end else if (cmd == CMD_PUSH) begin
         // Recycled nodes are preferred over fresh ones.
         if (free_list_head != NODE_NULL) begin
            node           = free_list_head;
            free_list_head = node_next[node[ADDR_W-1:0]];
         end else if (fresh_used < POOL_DEPTH) begin
            node = NODE_W'(fresh_used);
            fresh_used++;
         end else begin
            r.status = ST_EXHAUSTED;
         end
         if (r.status == ST_OK) begin
            node_data[node[ADDR_W-1:0]] = value;
            node_next[node[ADDR_W-1:0]] = top_of[idx];
            top_of[idx]                 = node;
         end
      end else begin
         node = top_of[idx];
         if (node == NODE_NULL) begin
            r.status    = ST_UNDERFLOW;
            r.pop_value = '1;
         end else begin
            r.pop_value                 = node_data[node[ADDR_W-1:0]];
            top_of[idx]                 = node_next[node[ADDR_W-1:0]];
            node_next[node[ADDR_W-1:0]] = free_list_head;
            free_list_head              = node;
         end
      end
      return r;
   endfunction

   // Track register writes and request beats, and compare every result beat.
   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         errors         = 0;
         active_count   = ACTIVE_RESET;
         free_list_head = NODE_NULL;
         fresh_used     = 0;
         for (int i = 0; i < MAX_STACKS; i++) top_of[i] = NODE_NULL;
         replies_due.delete();
      end else begin
         if (csr_valid && csr_ready) active_count = csr_data;
         if (req_tvalid && req_tready)
            replies_due.push_back(apply_stack_op(req_tuser[0], req_tuser[IDX_W:1], req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.pop_value = rsp_tdata;
            got.status    = rsp_tuser;
            if (replies_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, value %h status %0d",
                        $time, got.pop_value, got.status);
            end else begin
               want = replies_due.pop_front();
               if (want.pop_value !== got.pop_value) begin
                  errors++;
                  $display("%0t: pop_value expected %h, actual %h",
                           $time, want.pop_value, got.pop_value);
               end
               if (want.status !== got.status) begin
                  errors++;
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, got.status);
               end
            end
         end
      end
      pending = replies_due.size();
   end

endmodule

@@ test/multi_stack_shared_pool_test.sv @@
`timescale 1ns / 100ps

module multi_stack_shared_pool_test;
   import msp_pkg::*;

   localparam int CYCLE_LIMIT = 250000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_WIDTH-1:0] req_tdata;   // push_value
   logic [IDX_W:0]        req_tuser;   // command, stack_index
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_WIDTH-1:0] rsp_tdata;   // pop_value
   logic [STAT_W-1:0]     rsp_tuser;   // status
   logic                  csr_valid;
   logic                  csr_ready;
   logic [ACTIVE_W-1:0]   csr_data;    // active_stacks

   int errors;
   int pending;
   int churn;        // 0 no idling, 1 occasional, 2 frequent
   int stall_left;
   int cycle_count;
   int active_now;

   multi_stack_shared_pool i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   multi_stack_shared_pool_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Run guard.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result-side backpressure in random bursts.
   initial begin
      rsp_tready = 1'b1;
      stall_left = 0;
   end
   always @(negedge clock) begin
      if (churn == 0 || reset) begin
         rsp_tready = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, (churn == 2) ? 3 : 9) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Mostly random data, with the corner values mixed in.
   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         3:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         default: return $urandom;
      endcase
   endfunction

   // Sends one request beat, with an optional random gap ahead of it.
   task automatic send_op(input logic cmd, input int idx, input logic [DATA_WIDTH-1:0] value);
      if (churn != 0 && $urandom_range(0, (churn == 2) ? 2 : 8) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tuser  = {IDX_W'(idx), cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Writes active_stacks once every result so far has come back.
   task automatic write_active(input int count);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = ACTIVE_W'(count);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid  = 1'b0;
      active_now = count;
   endtask

   // Random mix of pushes and pops, mostly to stacks in range.
   task automatic run_mix(input int beats, input int push_pct);
      int   top_idx;
      int   idx;
      logic cmd;
      top_idx = (active_now < MAX_STACKS ? active_now : MAX_STACKS) - 1;
      for (int i = 0; i < beats; i++) begin
         cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
         if (top_idx < 0 || $urandom_range(0, 7) == 0) idx = $urandom_range(0, 7);
         else idx = $urandom_range(0, top_idx);
         send_op(cmd, idx, pick_value());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      churn      = 0;
      active_now = 8;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: underflow, extreme values, node reuse, then invalid indexes.
      send_op(CMD_POP,  0, '0);
      send_op(CMD_PUSH, 0, 32'h7FFF_FFFF);
      send_op(CMD_PUSH, 0, 32'h8000_0000);
      send_op(CMD_PUSH, 7, 32'hFFFF_FFFF);
      send_op(CMD_PUSH, 7, 32'h0000_0000);
      send_op(CMD_POP,  7, '1);
      send_op(CMD_POP,  0, '0);
      send_op(CMD_PUSH, 3, 32'hA5A5_A5A5);
      send_op(CMD_POP,  3, '0);
      send_op(CMD_POP,  7, '0);
      send_op(CMD_POP,  7, '0);
      send_op(CMD_POP,  0, '0);
      send_op(CMD_POP,  0, '0);
      write_active(2);
      send_op(CMD_PUSH, 2, 32'h1234_5678);
      send_op(CMD_POP,  7, '0);
      send_op(CMD_PUSH, 1, 32'h5A5A_5A5A);
      send_op(CMD_POP,  1, '0);
      send_op(CMD_POP,  1, '0);
      send_op(CMD_POP,  2, '0);

      // Random phases across several register settings.
      churn = 2;
      write_active(5);
      run_mix(30, 60);
      churn = 1;
      write_active(1);
      run_mix(30, 50);
      churn = 2;
      write_active(0);
      run_mix(15, 50);
      churn = 0;
      write_active(15);
      run_mix(30, 60);

      // Fill the pool past its size so that pushes are dropped, then drain part of it.
      churn = 1;
      write_active(8);
      for (int i = 0; i < POOL_DEPTH + 6; i++) send_op(CMD_PUSH, i % MAX_STACKS, pick_value());
      run_mix(25, 30);

      churn = 2;
      write_active(3);
      run_mix(30, 40);
      churn = 1;
      write_active($urandom_range(1, 8));
      run_mix(30, 45);

      // Closing stretch without any idling.
      churn = 0;
      run_mix(30, 50);

      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ multi_stack_shared_pool.f @@
rtl/msp_pkg.sv
rtl/msp_ram.sv
rtl/msp_dp.sv
rtl/msp_ctrl.sv
rtl/multi_stack_shared_pool.sv
test/multi_stack_shared_pool_checker.sv
test/multi_stack_shared_pool_test.sv
